[design/rdc_pkg.sv]
package rdc_pkg;

   // Event kinds carried by an input transaction
   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_TICK    = 3'd1;
   localparam logic [2:0] KIND_OPEN    = 3'd2;
   localparam logic [2:0] KIND_SEND    = 3'd3;
   localparam logic [2:0] KIND_CONSUME = 3'd4;
   localparam logic [2:0] KIND_CLOSE   = 3'd5;

   // Packet type codes
   localparam logic [7:0] PKT_PAYLOAD = 8'd0;
   localparam logic [7:0] PKT_ACK     = 8'd1;
   localparam logic [7:0] PKT_RESEND  = 8'd2;
   localparam logic [7:0] PKT_INIT    = 8'd3;
   localparam logic [7:0] PKT_CLOSE   = 8'd4;
   localparam logic [7:0] PKT_CLOSED  = 8'd5;
   localparam logic [7:0] PKT_PING    = 8'd6;
   localparam logic [7:0] PKT_PONG    = 8'd7;
   localparam logic [7:0] PKT_RESET   = 8'd8;

   // Status event codes
   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_DELIVERED = 3'd1;
   localparam logic [2:0] EV_BLOCK     = 3'd2;
   localparam logic [2:0] EV_EOS       = 3'd3;
   localparam logic [2:0] EV_CLOSED    = 3'd4;
   localparam logic [2:0] EV_RELEASED  = 3'd5;
   localparam logic [2:0] EV_DROPPED   = 3'd6;
   localparam logic [2:0] EV_FULL      = 3'd7;

   // Connection flag bit positions
   localparam int FLAG_INIT    = 0;
   localparam int FLAG_CLOSING = 1;
   localparam int FLAG_CLOSED  = 2;
   localparam int FLAG_PING    = 3;

   // Configuration register indexes
   localparam logic [1:0] CSR_PING_IDLE = 2'd0;
   localparam logic [1:0] CSR_DEAD_IDLE = 2'd1;

   // Reset values of the configuration registers
   localparam logic [7:0] PING_IDLE_RESET = 8'd20;
   localparam logic [7:0] DEAD_IDLE_RESET = 8'd120;

   // Most RESEND rows that one payload header can cause
   localparam logic [4:0] MAX_RESEND = 5'd31;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic scan;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic scan_start;
      logic scan_last;
   } status_type;

endpackage

[design/rdc_ctrl.sv]
module rdc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rdc_pkg::status_type status,
   output rdc_pkg::cmd_type    cmd
);
   import rdc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.out_free) state_in = status.scan_start ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.capture = req_valid;
         end
         ST_EXEC: cmd.exec = status.out_free;
         ST_SCAN: cmd.scan = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

endmodule

[design/rdc_dp.sv]
module rdc_dp #(
   parameter int RECV_WINDOW = 32,
   parameter int SEND_WINDOW = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  rdc_pkg::cmd_type    cmd,
   output rdc_pkg::status_type status,
   input  logic [2:0]          req_kind,
   input  logic [7:0]          req_pkt_type,
   input  logic [15:0]         req_pkt_seq,
   input  logic [31:0]         req_pkt_size,
   input  logic [15:0]         req_ack_seq,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_tx_valid,
   output logic [3:0]          rsp_tx_type,
   output logic [15:0]         rsp_tx_seq,
   output logic [15:0]         rsp_tx_word,
   output logic [2:0]          rsp_event_res,
   output logic [15:0]         rsp_deliver_seq,
   output logic                rsp_last
);
   import rdc_pkg::*;

   localparam int RIW = (RECV_WINDOW > 1) ? $clog2(RECV_WINDOW) : 1;
   localparam int SIW = (SEND_WINDOW > 1) ? $clog2(SEND_WINDOW) : 1;

   // Captured transaction
   logic [2:0]  kind_ff;
   logic [7:0]  type_ff;
   logic [15:0] seq_ff;
   logic [31:0] size_ff;
   logic [15:0] ack_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         type_ff <= req_pkt_type;
         seq_ff  <= req_pkt_seq;
         size_ff <= req_pkt_size;
         ack_ff  <= req_ack_seq;
      end
   end

   // Configuration registers
   logic [7:0] ping_idle_ff;
   logic [7:0] dead_idle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ping_idle_ff <= PING_IDLE_RESET;
         dead_idle_ff <= DEAD_IDLE_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_PING_IDLE) ping_idle_ff <= csr_data;
         if (csr_index == CSR_DEAD_IDLE) dead_idle_ff <= csr_data;
      end
   end

   // Connection state
   logic [3:0]             flags_ff, flags_in;
   logic [15:0]            nin_ff, nin_in;
   logic [15:0]            nout_ff, nout_in;
   logic [RECV_WINDOW-1:0] rmarks_ff, rmarks_in;
   logic [SEND_WINDOW-1:0] omarks_ff, omarks_in;
   logic [7:0]             idle_ff, idle_in;

   // Missing-sequence scan
   logic [RIW-1:0] idx_ff, idx_in;
   logic [RIW-1:0] end_ff, end_in;
   logic [4:0]     cnt_ff, cnt_in;

   // Result register
   logic        rv_ff, rv_in;
   logic        rtx_ff, rtx_in;
   logic [3:0]  rtype_ff, rtype_in;
   logic [15:0] rseq_ff, rseq_in;
   logic [15:0] rword_ff, rword_in;
   logic [2:0]  rev_ff, rev_in;
   logic [15:0] rdseq_ff, rdseq_in;
   logic        rlast_ff, rlast_in;

   logic        out_free;
   logic [15:0] ahead, back, off;
   logic [RIW:0] nxt_lo;
   logic        zero_first, zero_rest;
   logic        do_clear;
   logic [3:0]  clr_flags;
   logic [7:0]  idle_inc;
   logic        row_tx;
   logic [3:0]  row_type;
   logic [15:0] row_seq, row_word, row_dseq;
   logic [2:0]  row_ev;
   logic        row_last, row_load;

   assign out_free = !rv_ff || !rsp_stall;
   assign ahead    = seq_ff - nin_ff;
   assign back     = nin_ff - seq_ff;
   assign off      = nout_ff - 16'd1 - ack_ff;
   assign nxt_lo   = {1'b0, idx_ff} + 1'b1;
   assign idle_inc = (idle_ff == 8'hFF) ? idle_ff : idle_ff + 8'd1;

   // Unreceived marks below the new payload, and beyond the current scan position
   always_comb begin
      zero_first = 1'b0;
      zero_rest  = 1'b0;
      for (int j = 0; j < RECV_WINDOW; j++) begin
         if ((16'(j) < ahead) && !rmarks_ff[j]) zero_first = 1'b1;
         if (((RIW+1)'(j) >= nxt_lo) && (RIW'(j) < end_ff) && !rmarks_ff[j]) zero_rest = 1'b1;
      end
   end

   // Apply one transaction, or advance the scan
   always_comb begin
      flags_in  = flags_ff;
      nin_in    = nin_ff;
      nout_in   = nout_ff;
      rmarks_in = rmarks_ff;
      omarks_in = omarks_ff;
      idle_in   = idle_ff;
      idx_in    = idx_ff;
      end_in    = end_ff;
      cnt_in    = cnt_ff;
      do_clear  = 1'b0;
      clr_flags = 4'd0;
      row_tx    = 1'b0;
      row_type  = 4'd0;
      row_seq   = 16'd0;
      row_word  = 16'd0;
      row_ev    = EV_NONE;
      row_dseq  = 16'd0;
      row_last  = 1'b1;
      row_load  = 1'b0;
      status.out_free   = out_free;
      status.scan_start = 1'b0;
      status.scan_last  = 1'b0;

      if (cmd.exec) begin
         case (kind_ff)
            KIND_HEADER: begin
               idle_in = 8'd0;
               if (!flags_ff[FLAG_INIT] && type_ff != PKT_INIT) begin
                  row_tx = 1'b1;
                  row_type = PKT_RESET[3:0];
                  do_clear = 1'b1;
                  row_ev = EV_RELEASED;
               end else if (flags_ff[FLAG_CLOSING] && type_ff != PKT_CLOSED) begin
                  row_ev = EV_DROPPED;
               end else begin
                  case (type_ff)
                     PKT_ACK: begin
                        if (size_ff == 32'd2 && off < 16'(SEND_WINDOW))
                           omarks_in[off[SIW-1:0]] = 1'b0;
                     end
                     PKT_RESEND: row_ev = EV_NONE;
                     PKT_PAYLOAD: begin
                        if (ahead < 16'(RECV_WINDOW)) begin
                           row_tx = 1'b1;
                           row_type = PKT_ACK[3:0];
                           row_word = seq_ff;
                           rmarks_in[ahead[RIW-1:0]] = 1'b1;
                           idx_in = '0;
                           end_in = ahead[RIW-1:0];
                           cnt_in = 5'd0;
                           status.scan_start = zero_first;
                           row_last = !zero_first;
                        end else begin
                           if (back >= 16'd1 && back <= 16'(RECV_WINDOW)) begin
                              row_tx = 1'b1;
                              row_type = PKT_ACK[3:0];
                              row_word = seq_ff;
                           end
                           row_ev = EV_DROPPED;
                        end
                     end
                     PKT_INIT: begin
                        if (seq_ff != 16'd0 || size_ff != 32'd0) begin
                           row_tx = 1'b1;
                           row_type = PKT_RESET[3:0];
                           if (flags_ff[FLAG_INIT]) begin
                              flags_in[FLAG_CLOSED] = 1'b1;
                              row_ev = EV_CLOSED;
                           end else begin
                              do_clear = 1'b1;
                              row_ev = EV_RELEASED;
                           end
                        end else begin
                           flags_in[FLAG_INIT] = 1'b1;
                        end
                     end
                     PKT_CLOSE: begin
                        flags_in[FLAG_CLOSED] = 1'b1;
                        row_tx = 1'b1;
                        row_type = PKT_CLOSED[3:0];
                        row_ev = EV_CLOSED;
                     end
                     PKT_CLOSED: begin
                        if (flags_ff[FLAG_CLOSING]) begin
                           do_clear = 1'b1;
                           row_ev = EV_RELEASED;
                        end
                     end
                     PKT_PING: begin
                        row_tx = 1'b1;
                        row_type = PKT_PONG[3:0];
                        flags_in[FLAG_PING] = 1'b0;
                     end
                     PKT_PONG: flags_in[FLAG_PING] = 1'b0;
                     PKT_RESET: begin
                        flags_in[FLAG_CLOSED] = 1'b1;
                        row_ev = EV_CLOSED;
                     end
                     default: row_ev = EV_DROPPED;
                  endcase
               end
            end
            KIND_TICK: begin
               if (flags_ff != 4'd0) begin
                  idle_in = idle_inc;
                  if (!flags_ff[FLAG_CLOSED] && !rmarks_ff[0]) begin
                     if (idle_inc > ping_idle_ff && !flags_ff[FLAG_PING]) begin
                        flags_in[FLAG_PING] = 1'b1;
                        row_tx = 1'b1;
                        row_type = PKT_PING[3:0];
                     end else if (idle_inc > dead_idle_ff) begin
                        if (flags_ff[FLAG_CLOSING]) begin
                           do_clear = 1'b1;
                           row_ev = EV_RELEASED;
                        end else begin
                           flags_in[FLAG_CLOSED] = 1'b1;
                           row_ev = EV_CLOSED;
                        end
                     end
                  end
               end
            end
            KIND_OPEN: begin
               do_clear = 1'b1;
               clr_flags[FLAG_INIT] = 1'b1;
               row_tx = 1'b1;
               row_type = PKT_INIT[3:0];
            end
            KIND_SEND: begin
               if (flags_ff == 4'd0 || flags_ff[FLAG_CLOSED] || flags_ff[FLAG_CLOSING]) begin
                  row_ev = EV_EOS;
               end else if (omarks_ff[SEND_WINDOW-1]) begin
                  row_ev = EV_FULL;
               end else begin
                  row_tx = 1'b1;
                  row_type = PKT_PAYLOAD[3:0];
                  row_seq = nout_ff;
                  omarks_in = {omarks_ff[SEND_WINDOW-2:0], 1'b1};
                  nout_in = nout_ff + 16'd1;
               end
            end
            KIND_CONSUME: begin
               if (flags_ff == 4'd0 || flags_ff[FLAG_CLOSED] || flags_ff[FLAG_CLOSING]) begin
                  row_ev = EV_EOS;
               end else if (rmarks_ff[0]) begin
                  row_ev = EV_DELIVERED;
                  row_dseq = nin_ff;
                  rmarks_in = {1'b0, rmarks_ff[RECV_WINDOW-1:1]};
                  nin_in = nin_ff + 16'd1;
               end else begin
                  row_ev = EV_BLOCK;
               end
            end
            KIND_CLOSE: begin
               if (flags_ff != 4'd0) begin
                  if (flags_ff[FLAG_CLOSED]) begin
                     do_clear = 1'b1;
                     row_ev = EV_RELEASED;
                  end else begin
                     flags_in[FLAG_CLOSING] = 1'b1;
                     row_tx = 1'b1;
                     row_type = PKT_CLOSE[3:0];
                  end
               end
            end
            default: row_ev = EV_NONE;
         endcase
         row_load = row_tx || (row_ev != EV_NONE);
      end else if (cmd.scan) begin
         // One window position per cycle; a gap waits for the result register
         if (rmarks_ff[idx_ff]) begin
            idx_in = idx_ff + 1'b1;
         end else if (out_free) begin
            row_tx   = 1'b1;
            row_type = PKT_RESEND[3:0];
            row_word = nin_ff + 16'(idx_ff);
            row_last = (cnt_ff == MAX_RESEND - 5'd1) || !zero_rest;
            row_load = 1'b1;
            idx_in   = idx_ff + 1'b1;
            cnt_in   = cnt_ff + 5'd1;
            status.scan_last = row_last;
         end
      end

      // Releasing or opening the connection clears its state; opening leaves only FLAG_INIT set
      if (do_clear) begin
         flags_in  = clr_flags;
         nin_in    = 16'd0;
         nout_in   = 16'd0;
         rmarks_in = '0;
         omarks_in = '0;
         idle_in   = 8'd0;
      end
   end

   // Result register: loaded by a new row, emptied when the receiver takes the row
   always_comb begin
      rv_in    = rv_ff && rsp_stall;
      rtx_in   = rtx_ff;
      rtype_in = rtype_ff;
      rseq_in  = rseq_ff;
      rword_in = rword_ff;
      rev_in   = rev_ff;
      rdseq_in = rdseq_ff;
      rlast_in = rlast_ff;
      if (row_load) begin
         rv_in    = 1'b1;
         rtx_in   = row_tx;
         rtype_in = row_type;
         rseq_in  = row_seq;
         rword_in = row_word;
         rev_in   = row_ev;
         rdseq_in = row_dseq;
         rlast_in = row_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff     <= 1'b0;
         flags_ff  <= 4'd0;
         nin_ff    <= 16'd0;
         nout_ff   <= 16'd0;
         rmarks_ff <= '0;
         omarks_ff <= '0;
         idle_ff   <= 8'd0;
         idx_ff    <= '0;
         end_ff    <= '0;
         cnt_ff    <= 5'd0;
      end else begin
         rv_ff     <= rv_in;
         flags_ff  <= flags_in;
         nin_ff    <= nin_in;
         nout_ff   <= nout_in;
         rmarks_ff <= rmarks_in;
         omarks_ff <= omarks_in;
         idle_ff   <= idle_in;
         idx_ff    <= idx_in;
         end_ff    <= end_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rtx_ff   <= rtx_in;
      rtype_ff <= rtype_in;
      rseq_ff  <= rseq_in;
      rword_ff <= rword_in;
      rev_ff   <= rev_in;
      rdseq_ff <= rdseq_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_tx_valid    = rtx_ff;
   assign rsp_tx_type     = rtype_ff;
   assign rsp_tx_seq      = rseq_ff;
   assign rsp_tx_word     = rword_ff;
   assign rsp_event_res   = rev_ff;
   assign rsp_deliver_seq = rdseq_ff;
   assign rsp_last        = rlast_ff;

endmodule

[design/reliable_datagram_connection_ctrl.sv]
// Flow: a transaction is accepted while idle and executed once the result register is free, and its
// result row is registered; a new transaction is taken only after the last one's rows are loaded.
// A payload that opens a gap adds a missing-sequence scan that walks the receive-window
// positions below it (up to RECV_WINDOW-1).
// Reset: synchronous, active high; clears the connection and loads ping/dead limits 20/120.
module reliable_datagram_connection_ctrl #(
   parameter int RECV_WINDOW = 32,
   parameter int SEND_WINDOW = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_pkt_type,
   input  logic [15:0] req_pkt_seq,
   input  logic [31:0] req_pkt_size,
   input  logic [15:0] req_ack_seq,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_valid,
   output logic [3:0]  rsp_tx_type,
   output logic [15:0] rsp_tx_seq,
   output logic [15:0] rsp_tx_word,
   output logic [2:0]  rsp_event_res,
   output logic [15:0] rsp_deliver_seq,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import rdc_pkg::*;

   cmd_type    cmd;
   status_type status;

   rdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rdc_dp #(
      .RECV_WINDOW (RECV_WINDOW),
      .SEND_WINDOW (SEND_WINDOW)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_pkt_type    (req_pkt_type),
      .req_pkt_seq     (req_pkt_seq),
      .req_pkt_size    (req_pkt_size),
      .req_ack_seq     (req_ack_seq),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_type     (rsp_tx_type),
      .rsp_tx_seq      (rsp_tx_seq),
      .rsp_tx_word     (rsp_tx_word),
      .rsp_event_res   (rsp_event_res),
      .rsp_deliver_seq (rsp_deliver_seq),
      .rsp_last        (rsp_last)
   );

endmodule

[dv/rdc_checker.sv]
module rdc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_pkt_type,
   input  logic [15:0] req_pkt_seq,
   input  logic [31:0] req_pkt_size,
   input  logic [15:0] req_ack_seq,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_tx_valid,
   input  logic [3:0]  rsp_tx_type,
   input  logic [15:0] rsp_tx_seq,
   input  logic [15:0] rsp_tx_word,
   input  logic [2:0]  rsp_event_res,
   input  logic [15:0] rsp_deliver_seq,
   input  logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          fail_count,
   output int          pending_count
);
   import rdc_pkg::*;

   typedef struct packed {
      logic        tx_valid;
      logic [3:0]  tx_type;
      logic [15:0] tx_seq;
      logic [15:0] tx_word;
      logic [2:0]  event_res;
      logic [15:0] deliver_seq;
      logic        last;
   } row_type;

   row_type expected_rows[$];
   row_type new_rows[$];

   // Mirror of the connection state and the limits
   logic [7:0]  ping_limit, dead_limit;
   logic [3:0]  flags;
   logic [15:0] in_seq, out_seq;
   logic [31:0] recv_marks, out_marks;
   logic [7:0]  idle;

   function automatic void clear_conn();
      flags = '0;
      in_seq = '0;
      out_seq = '0;
      recv_marks = '0;
      out_marks = '0;
      idle = '0;
   endfunction

   function automatic void add_tx(logic [7:0] typ, logic [15:0] seq, logic [15:0] word);
      row_type r;
      r = '0;
      r.tx_valid = 1'b1;
      r.tx_type = typ[3:0];
      r.tx_seq = seq;
      r.tx_word = word;
      if (new_rows.size() < 32) new_rows.push_back(r);
   endfunction

   // Payload header: ACK and RESEND list for a gap, or a drop
   function automatic logic [2:0] take_payload(logic [15:0] seq);
      logic [15:0] d, back;
      int budget;
      d = seq - in_seq;
      back = in_seq - seq;
      budget = 31;
      if (d < 32) begin
         add_tx(PKT_ACK, 16'd0, seq);
         recv_marks[d[4:0]] = 1'b1;
         for (int i = 0; i < d && budget > 0; i++) begin
            if (!recv_marks[i]) begin
               add_tx(PKT_RESEND, 16'd0, in_seq + 16'(i));
               budget--;
            end
         end
         return EV_NONE;
      end
      if (back >= 1 && back <= 32) add_tx(PKT_ACK, 16'd0, seq);
      return EV_DROPPED;
   endfunction

   function automatic logic [2:0] take_header(logic [7:0] typ, logic [15:0] seq,
                                              logic [31:0] size, logic [15:0] aseq);
      logic [15:0] off;
      idle = '0;
      if (!flags[FLAG_INIT] && typ != PKT_INIT) begin
         add_tx(PKT_RESET, 16'd0, 16'd0);
         clear_conn();
         return EV_RELEASED;
      end
      if (flags[FLAG_CLOSING] && typ != PKT_CLOSED) return EV_DROPPED;
      case (typ)
         PKT_ACK: begin
            off = out_seq - 16'd1 - aseq;
            if (size == 32'd2 && off < 32) out_marks[off[4:0]] = 1'b0;
            return EV_NONE;
         end
         PKT_RESEND: return EV_NONE;
         PKT_PAYLOAD: return take_payload(seq);
         PKT_INIT: begin
            if (seq != 0 || size != 0) begin
               add_tx(PKT_RESET, 16'd0, 16'd0);
               if (flags[FLAG_INIT]) begin
                  flags[FLAG_CLOSED] = 1'b1;
                  return EV_CLOSED;
               end
               clear_conn();
               return EV_RELEASED;
            end
            flags[FLAG_INIT] = 1'b1;
            return EV_NONE;
         end
         PKT_CLOSE: begin
            flags[FLAG_CLOSED] = 1'b1;
            add_tx(PKT_CLOSED, 16'd0, 16'd0);
            return EV_CLOSED;
         end
         PKT_CLOSED: begin
            if (flags[FLAG_CLOSING]) begin
               clear_conn();
               return EV_RELEASED;
            end
            return EV_NONE;
         end
         PKT_PING: begin
            add_tx(PKT_PONG, 16'd0, 16'd0);
            flags[FLAG_PING] = 1'b0;
            return EV_NONE;
         end
         PKT_PONG: begin
            flags[FLAG_PING] = 1'b0;
            return EV_NONE;
         end
         PKT_RESET: begin
            flags[FLAG_CLOSED] = 1'b1;
            return EV_CLOSED;
         end
         default: return EV_DROPPED;
      endcase
   endfunction

   function automatic logic [2:0] take_tick();
      if (flags == 0) return EV_NONE;
      if (idle != 8'hFF) idle++;
      if (flags[FLAG_CLOSED] || recv_marks[0]) return EV_NONE;
      if (idle > ping_limit && !flags[FLAG_PING]) begin
         flags[FLAG_PING] = 1'b1;
         add_tx(PKT_PING, 16'd0, 16'd0);
         return EV_NONE;
      end
      if (idle > dead_limit) begin
         if (flags[FLAG_CLOSING]) begin
            clear_conn();
            return EV_RELEASED;
         end
         flags[FLAG_CLOSED] = 1'b1;
         return EV_CLOSED;
      end
      return EV_NONE;
   endfunction

   // Predict the rows of one transaction and queue them
   function automatic void predict_event(logic [2:0] kind, logic [7:0] typ, logic [15:0] seq,
                                         logic [31:0] size, logic [15:0] aseq);
      logic [2:0]  ev;
      logic [15:0] dseq;
      logic        dead;
      row_type     r;
      ev = EV_NONE;
      dseq = '0;
      new_rows.delete();
      dead = (flags == 0) || flags[FLAG_CLOSED] || flags[FLAG_CLOSING];
      case (kind)
         KIND_HEADER: ev = take_header(typ, seq, size, aseq);
         KIND_TICK: ev = take_tick();
         KIND_OPEN: begin
            clear_conn();
            flags[FLAG_INIT] = 1'b1;
            add_tx(PKT_INIT, 16'd0, 16'd0);
         end
         KIND_SEND: begin
            if (dead) ev = EV_EOS;
            else if (out_marks[31]) ev = EV_FULL;
            else begin
               add_tx(PKT_PAYLOAD, out_seq, 16'd0);
               out_marks = {out_marks[30:0], 1'b1};
               out_seq++;
            end
         end
         KIND_CONSUME: begin
            if (dead) ev = EV_EOS;
            else if (recv_marks[0]) begin
               ev = EV_DELIVERED;
               dseq = in_seq;
               recv_marks = recv_marks >> 1;
               in_seq++;
            end else ev = EV_BLOCK;
         end
         KIND_CLOSE: begin
            if (flags[FLAG_CLOSED]) begin
               clear_conn();
               ev = EV_RELEASED;
            end else if (flags != 0) begin
               flags[FLAG_CLOSING] = 1'b1;
               add_tx(PKT_CLOSE, 16'd0, 16'd0);
            end
         end
         default: ;
      endcase
      if (ev != EV_NONE) begin
         if (new_rows.size() == 0) begin
            r = '0;
            new_rows.push_back(r);
         end
         new_rows[$].event_res = ev;
         new_rows[$].deliver_seq = (ev == EV_DELIVERED) ? dseq : 16'd0;
      end
      if (new_rows.size() > 0) new_rows[$].last = 1'b1;
      foreach (new_rows[i]) expected_rows.push_back(new_rows[i]);
   endfunction

   // Watch both channels and the register port
   always @(posedge clock) begin
      row_type got, want;
      if (reset) begin
         ping_limit = PING_IDLE_RESET;
         dead_limit = DEAD_IDLE_RESET;
         clear_conn();
         expected_rows.delete();
         fail_count <= 0;
      end else begin
         if (csr_we && csr_index == CSR_PING_IDLE) ping_limit = csr_data;
         if (csr_we && csr_index == CSR_DEAD_IDLE) dead_limit = csr_data;
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_tx_valid, rsp_tx_type, rsp_tx_seq, rsp_tx_word,
                   rsp_event_res, rsp_deliver_seq, rsp_last};
            if (expected_rows.size() == 0) begin
               $display("%0t: unexpected transaction, expected none actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rows.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            predict_event(req_kind, req_pkt_type, req_pkt_seq, req_pkt_size, req_ack_seq);
      end
      pending_count <= expected_rows.size();
   end

endmodule

[dv/tb.sv]
module tb;
   import rdc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = '0;
   logic [7:0]  req_pkt_type = '0;
   logic [15:0] req_pkt_seq = '0;
   logic [31:0] req_pkt_size = '0;
   logic [15:0] req_ack_seq = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_tx_valid;
   logic [3:0]  rsp_tx_type;
   logic [15:0] rsp_tx_seq;
   logic [15:0] rsp_tx_word;
   logic [2:0]  rsp_event_res;
   logic [15:0] rsp_deliver_seq;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;
   int          fail_count, pending_count;
   int          send_idle_pct = 0, recv_idle_pct = 0;
   int          hold_cycles = 0;
   logic        hold_start = 1'b0;
   logic        hold_used = 1'b0;
   int          cycle_count = 0;
   logic [15:0] seq_base = '0;

   always #5 clock = ~clock;

   reliable_datagram_connection_ctrl dut (.*);

   rdc_checker checker_i (.*);

   // Receiver stall: a long hold-off once asked, otherwise random
   always @(posedge clock) begin
      if (hold_start && !hold_used) begin
         hold_used <= 1'b1;
         hold_cycles <= 300;
         rsp_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offer one transaction and hold it until it is taken
   task automatic put_event(logic [2:0] kind, logic [7:0] typ, logic [15:0] seq,
                            logic [31:0] size, logic [15:0] aseq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_pkt_type <= typ;
      req_pkt_seq <= seq;
      req_pkt_size <= size;
      req_ack_seq <= aseq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic put_header(logic [7:0] typ, logic [15:0] seq, logic [31:0] size);
      put_event(KIND_HEADER, typ, seq, size, 16'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] val);
      req_valid <= 1'b0;
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // One random transaction, mostly well formed around the live sequences
   task automatic random_event();
      int pick;
      logic [7:0] typ;
      pick = $urandom_range(99);
      if (pick < 5)
         put_event(KIND_OPEN, 8'($urandom), 16'($urandom), $urandom, 16'($urandom));
      else if (pick < 25)
         put_event(KIND_SEND, 8'($urandom), 16'($urandom), $urandom, 16'($urandom));
      else if (pick < 40)
         put_event(KIND_CONSUME, 8'($urandom), 16'($urandom), $urandom, 16'($urandom));
      else if (pick < 50)
         put_event(KIND_TICK, 8'($urandom), 16'($urandom), $urandom, 16'($urandom));
      else if (pick < 53)
         put_event(KIND_CLOSE, 8'($urandom), 16'($urandom), $urandom, 16'($urandom));
      else if (pick < 55)
         put_event(3'($urandom_range(7)), 8'($urandom), 16'($urandom), $urandom,
                   16'($urandom));
      else if (pick < 78) begin
         // Payload near the receive window
         put_header(PKT_PAYLOAD, seq_base + 16'($urandom_range(40)) - 16'd4, $urandom);
         if ($urandom_range(3) == 0) seq_base = seq_base + 16'd1;
      end else if (pick < 88) begin
         put_event(KIND_HEADER, PKT_ACK, 16'($urandom),
                   ($urandom_range(3) == 0) ? $urandom : 32'd2, 16'($urandom_range(40)));
      end else begin
         typ = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(8));
         if (typ == PKT_INIT && $urandom_range(1) == 0) put_header(typ, 16'd0, 32'd0);
         else put_header(typ, 16'($urandom), ($urandom_range(1) == 0) ? 32'd0 : $urandom);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_csr(CSR_PING_IDLE, 8'd2);
      write_csr(CSR_DEAD_IDLE, 8'd4);

      // Directed part
      put_header(PKT_PING, 16'hFFFF, 32'hFFFF_FFFF);
      put_event(KIND_CLOSE, '0, '0, '0, '0);
      put_event(KIND_SEND, '0, '0, '0, '0);
      put_header(PKT_INIT, 16'd5, 32'd0);
      put_header(PKT_INIT, 16'd0, 32'd0);
      put_header(PKT_INIT, 16'd0, 32'd1);
      put_event(KIND_OPEN, '0, '0, '0, '0);
      put_header(PKT_PAYLOAD, 16'd31, 32'd0);
      put_header(PKT_PAYLOAD, 16'd0, 32'd0);
      put_event(KIND_CONSUME, '0, '0, '0, '0);
      put_event(KIND_CONSUME, '0, '0, '0, '0);
      put_header(PKT_PAYLOAD, 16'd0, 32'd0);
      put_header(PKT_PAYLOAD, 16'd900, 32'd0);
      put_event(KIND_SEND, '0, '0, '0, '0);
      put_event(KIND_HEADER, PKT_ACK, '0, 32'd2, 16'd0);
      put_header(PKT_RESEND, '0, '0);
      put_header(PKT_PONG, '0, '0);
      put_header(8'hFF, '0, '0);
      repeat (6) put_event(KIND_TICK, '0, '0, '0, '0);
      put_event(KIND_CLOSE, '0, '0, '0, '0);
      put_header(PKT_CLOSE, '0, '0);
      put_header(PKT_CLOSED, '0, '0);
      put_event(KIND_OPEN, '0, '0, '0, '0);
      put_header(PKT_RESET, '0, '0);
      put_header(PKT_CLOSE, '0, '0);
      drain();
      write_csr(CSR_PING_IDLE, 8'd255);
      write_csr(CSR_DEAD_IDLE, 8'd255);
      put_event(KIND_OPEN, '0, '0, '0, '0);
      repeat (34) put_event(KIND_SEND, '0, '0, '0, '0);

      // Long receiver hold-off while the sender keeps offering
      hold_start <= 1'b1;
      repeat (10) put_event(KIND_CONSUME, '0, '0, '0, '0);
      drain();

      // Random phases under the three idling patterns
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 58 : 0;
         recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 37 : 0;
         write_csr(CSR_PING_IDLE, (phase == 0) ? 8'd1 : 8'($urandom_range(1, 8)));
         write_csr(CSR_DEAD_IDLE, (phase == 1) ? 8'd1 : 8'($urandom_range(3, 12)));
         seq_base = '0;
         put_event(KIND_OPEN, '0, '0, '0, '0);
         repeat (75) random_event();
         drain();
      end

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[files.f]
design/rdc_pkg.sv
design/rdc_ctrl.sv
design/rdc_dp.sv
design/reliable_datagram_connection_ctrl.sv
dv/rdc_checker.sv
dv/tb.sv
